>>> rtl/gfbm_pkg.sv
// ----------------------------------------------------------------------------
// gfbm_pkg
// Types and constants shared by the GF(2^8) Berlekamp-Massey block.
// ----------------------------------------------------------------------------
package gfbm_pkg;

	localparam int SYM_W = 8;
	localparam int POLY_W = 9;
	localparam int IDX_W = 5;
	localparam int LEN_W = 6;
	localparam logic [POLY_W-1:0] POLY_RESET = 9'h11D;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} in_beat_t;

	typedef struct packed {
		logic [SYM_W-1:0] coefficient;
		logic [IDX_W-1:0] coefficient_index;
		logic [LEN_W-1:0] poly_length;
		logic             final_result;
		logic             overflow;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISC,
		ST_DECIDE,
		ST_INV,
		ST_KMUL,
		ST_BUILD,
		ST_EMIT,
		ST_CLEAR
	} state_t;

	// multiply-unit operand select
	typedef enum logic [1:0] {
		MS_DISC,
		MS_INV,
		MS_KMUL,
		MS_BUILD
	} msel_t;

	// one shift-and-xor multiply over the configured reduction polynomial
	function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
		input logic [SYM_W-1:0] b, input logic [POLY_W-1:0] p);
		logic [SYM_W:0]   x;
		logic [SYM_W-1:0] acc;
		x = {1'b0, a};
		acc = '0;
		for (int n = 0; n < SYM_W; n++) begin
			if (b[n]) acc = acc ^ x[SYM_W-1:0];
			x = {x[SYM_W-1:0], 1'b0};
			if (x[SYM_W]) x = x ^ p;
			x[SYM_W] = 1'b0;
		end
		return acc;
	endfunction

endpackage

>>> rtl/gfbm_if.sv
// ----------------------------------------------------------------------------
// gfbm_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface gfbm_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/gfbm_mul.sv
// ----------------------------------------------------------------------------
// gfbm_mul
// Shared GF(2^8) multiplier with registered product.
// ----------------------------------------------------------------------------
module gfbm_mul (
	input  logic                          clk,
	input  logic [gfbm_pkg::SYM_W-1:0]    a,
	input  logic [gfbm_pkg::SYM_W-1:0]    b,
	input  logic [gfbm_pkg::POLY_W-1:0]   poly,
	output logic [gfbm_pkg::SYM_W-1:0]    prod_q
);
	import gfbm_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= gf_mul(a, b, poly);
	end
endmodule

>>> rtl/gf256_berlekamp_massey.sv
// Sequencing: each symbol holds the block for a discrepancy pass over L, the current length.
// A non-zero discrepancy after the first failure adds an inverse, a scale and a top-down
// rebuild phase. A last beat adds L output beats (one when L is 0) and a MAX_LEN-entry clear.
// Throughput: one symbol at a time; set by the single shared multiplier.
// Reset: arst_n clears all control state; polynomial stores are cleared
// by the end-of-run sweep and treated as zero via length counts after reset.
// ----------------------------------------------------------------------------
// gf256_berlekamp_massey
// Streaming Berlekamp-Massey over GF(2^8) using one shared multiplier.
// ----------------------------------------------------------------------------
module gf256_berlekamp_massey #(
	parameter int MAX_LEN = 32
) (
	input  logic clk,
	input  logic arst_n,
	gfbm_if.sink   in_ch,
	gfbm_if.source out_ch,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gfbm_pkg::POLY_W-1:0] cfg_data
);
	import gfbm_pkg::*;

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1) + 1;

	state_t state_q, state_d;
	logic [POLY_W-1:0] poly_q;

	logic [SYM_W-1:0] seq_mem [MAX_LEN];
	logic [SYM_W-1:0] cur_q [MAX_LEN];
	logic [SYM_W-1:0] bst_q [MAX_LEN];

	logic [CW-1:0] cur_len_q, bst_len_q, fail_pos_q, cnt_q, i_q;
	logic [SYM_W-1:0] bst_disc_q, dt_q, k_q, inv_q, base_q;
	logic seen_q, ovf_q, last_q;
	logic [CW-1:0] j_q;
	logic [3:0] step_q;
	logic pend_q;
	logic vld_s1;
	logic [CW-1:0] shift_q;
	logic take_bst_q;

	logic [SYM_W-1:0] seq_rd_s1, cur_rd_s1;
	logic [SYM_W-1:0] ma, mb, prod_q;
	msel_t msel;

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ch.ready = (state_q == ST_IDLE);

	wire acc_in = in_ch.valid && in_ch.ready;
	wire out_fire = out_ch.valid && out_ch.ready;

	gfbm_mul u_mul (.clk(clk), .a(ma), .b(mb), .poly(poly_q), .prod_q(prod_q));

	// next connection length: max(shift + best length + 1, current length), capped at MAX_LEN
	logic [CW:0] lim_w;
	logic [CW-1:0] newlen_w;
	always_comb begin
		lim_w = {1'b0, shift_q} + {1'b0, bst_len_q} + 1'b1;
		if (lim_w < {1'b0, cur_len_q}) lim_w = {1'b0, cur_len_q};
		if (lim_w > (CW+1)'(MAX_LEN)) lim_w = (CW+1)'(MAX_LEN);
		newlen_w = lim_w[CW-1:0];
	end

	// multiplier operands
	logic [SYM_W-1:0] bsel;
	logic [CW:0] bidx;
	always_comb begin
		bidx = {1'b0, j_q} - {1'b0, shift_q} - 1'b1;
		bsel = (bidx < {1'b0, bst_len_q}) ? bst_q[bidx[AW-1:0]] : '0;
	end
	always_comb begin
		unique case (msel)
			MS_DISC:  begin ma = cur_rd_s1; mb = seq_rd_s1; end
			MS_INV:   begin ma = step_q[0] ? base_q : inv_q; mb = base_q; end
			MS_KMUL:  begin ma = dt_q; mb = inv_q; end
			MS_BUILD: begin ma = bsel; mb = k_q; end
			default:  begin ma = '0; mb = '0; end
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_INV:   msel = MS_INV;
			ST_KMUL:  msel = MS_KMUL;
			ST_BUILD: msel = MS_BUILD;
			default:  msel = MS_DISC;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (acc_in) state_d = ST_DISC;
			ST_DISC:   if (!pend_q && !vld_s1 && j_q >= cur_len_q) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (dt_q == '0 || !seen_q) state_d = last_q ? ST_EMIT : ST_IDLE;
				else state_d = ST_INV;
			end
			ST_INV:    if (step_q == 4'd15 && pend_q) state_d = ST_KMUL;
			ST_KMUL:   if (pend_q) state_d = ST_BUILD;
			ST_BUILD:  if (j_q == '0 && pend_q)
				state_d = last_q ? ST_EMIT : ST_IDLE;
			ST_EMIT:   if (out_fire && (j_q + 1'b1 >= cur_len_q)) state_d = ST_CLEAR;
			ST_CLEAR:  if (j_q == CW'(MAX_LEN - 1)) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// output beat
	always_comb begin
		out_ch.valid = (state_q == ST_EMIT);
		out_ch.data.coefficient = (cur_len_q == '0) ? '0 : cur_q[j_q[AW-1:0]];
		out_ch.data.coefficient_index = IDX_W'(j_q);
		out_ch.data.poly_length = LEN_W'(cur_len_q);
		out_ch.data.final_result = (j_q + 1'b1 >= cur_len_q);
		out_ch.data.overflow = ovf_q;
	end

	// sequence memory: write on accept, registered read
	logic [CW:0] ridx;
	always_comb ridx = {1'b0, i_q} - {1'b0, j_q} - 2'd2;
	always_ff @(posedge clk) begin
		if (acc_in && cnt_q < CW'(MAX_LEN)) seq_mem[cnt_q[AW-1:0]] <= in_ch.data.symbol;
		seq_rd_s1 <= seq_mem[ridx[AW-1:0]];
		cur_rd_s1 <= cur_q[j_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			poly_q <= POLY_RESET;
			cur_len_q <= '0; bst_len_q <= '0; fail_pos_q <= '0; cnt_q <= '0; i_q <= '0;
			bst_disc_q <= '0; seen_q <= 1'b0; ovf_q <= 1'b0; last_q <= 1'b0;
			j_q <= '0; step_q <= '0; pend_q <= 1'b0; vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) poly_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: if (acc_in) begin
					last_q <= in_ch.data.last;
					pend_q <= 1'b0;
					vld_s1 <= 1'b0;
					if (cnt_q >= CW'(MAX_LEN)) begin
						ovf_q <= 1'b1;
						j_q <= cur_len_q; // skip discrepancy, force no change
						dt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						i_q <= cnt_q + 1'b1;
						j_q <= '0;
						dt_q <= in_ch.data.symbol;
					end
				end
				ST_DISC: begin
					// read, multiply, accumulate: each term passes the registered reads and the registered product
					// before it is added into dt_q; terms with i < j+2 contribute nothing
					if (pend_q) dt_q <= dt_q ^ prod_q;
					pend_q <= vld_s1;
					vld_s1 <= (j_q < cur_len_q && i_q >= j_q + 2'd2);
					if (j_q < cur_len_q) j_q <= j_q + 1'b1;
				end
				ST_DECIDE: begin
					j_q <= '0; step_q <= '0; pend_q <= 1'b0;
					if (dt_q != '0 && !seen_q) begin
						seen_q <= 1'b1;
						for (int m = 0; m < MAX_LEN; m++) cur_q[m] <= '0;
						cur_len_q <= i_q; fail_pos_q <= i_q;
						bst_disc_q <= dt_q; bst_len_q <= '0;
					end
					inv_q <= 8'd1; base_q <= bst_disc_q;
					shift_q <= i_q - fail_pos_q - 1'b1;
					take_bst_q <= (i_q - fail_pos_q + bst_len_q >= cur_len_q);
				end
				ST_INV: begin
					// square-and-multiply for b^254: bits 1..7 set, bit0 clear
					pend_q <= !pend_q;
					if (pend_q) begin
						if (step_q[0]) base_q <= prod_q;
						else if (step_q[3:1] != 3'd0) inv_q <= prod_q;
						step_q <= step_q + 1'b1;
					end
				end
				ST_KMUL: begin
					pend_q <= !pend_q;
					if (pend_q) begin
						k_q <= prod_q; j_q <= CW'(MAX_LEN - 1);
					end
				end
				ST_BUILD: begin
					// next[] terms are written in place, each after its registered product
					// top index first so old best taps are read before the copy lands
					pend_q <= !pend_q;
					if (pend_q) begin
						if (take_bst_q) bst_q[j_q[AW-1:0]] <= cur_q[j_q[AW-1:0]];
						cur_q[j_q[AW-1:0]] <= ((j_q < cur_len_q) ? cur_q[j_q[AW-1:0]] : '0)
							^ ((j_q == shift_q) ? k_q :
							   (j_q > shift_q) ? prod_q : '0);
						if (j_q == '0) begin
							cur_len_q <= newlen_w;
							if (take_bst_q) begin
								bst_len_q <= cur_len_q; fail_pos_q <= i_q; bst_disc_q <= dt_q;
							end
						end
						j_q <= (j_q == '0) ? '0 : j_q - 1'b1;
					end
				end
				ST_EMIT: if (out_fire) begin
					j_q <= (state_d == ST_CLEAR) ? '0 : j_q + 1'b1;
				end
				ST_CLEAR: begin
					cur_q[j_q[AW-1:0]] <= '0; bst_q[j_q[AW-1:0]] <= '0;
					j_q <= (state_d == ST_IDLE) ? '0 : j_q + 1'b1;
					cur_len_q <= '0; bst_len_q <= '0; fail_pos_q <= '0; cnt_q <= '0;
					bst_disc_q <= '0; seen_q <= 1'b0; ovf_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/gfbm_chk.sv
// ----------------------------------------------------------------------------
// gfbm_chk
// Port-level checks for the Berlekamp-Massey block.
// ----------------------------------------------------------------------------
module gfbm_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [gfbm_pkg::IDX_W-1:0] out_idx,
	input logic [gfbm_pkg::LEN_W-1:0] out_len,
	input logic out_final
);
	import gfbm_pkg::*;

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready during output beats");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("output beat dropped");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_final |=> out_valid &&
		out_idx == $past(out_idx) + 1'b1) else $error("coefficient index skipped");
	a_len_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_final |=> out_len == $past(out_len))
		else $error("length changed within run");
endmodule

bind gf256_berlekamp_massey gfbm_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_idx(out_ch.data.coefficient_index), .out_len(out_ch.data.poly_length),
	.out_final(out_ch.data.final_result)
);

>>> tb/gfbm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbm_checker
// Watches the symbol, coefficient and config channels, runs a Berlekamp-Massey
// predictor over GF(2^8) and compares every coefficient beat with it.
// ----------------------------------------------------------------------------
module gfbm_checker
	import gfbm_pkg::*;
#(
	parameter int MAX_LEN = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  in_beat_t            in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  out_beat_t           out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [POLY_W-1:0]   cfg_data,
	output int                  fail_count,
	output int                  pending,
	output int                  runs_done,
	output int                  coefs_seen
);

	logic [POLY_W-1:0] reduce_poly;
	logic [7:0] seq_mem [MAX_LEN];
	logic [7:0] conn [MAX_LEN];
	logic [7:0] prev_conn [MAX_LEN];
	int unsigned conn_len, prev_len, prev_pos, sym_cnt;
	logic [7:0] prev_disc;
	bit had_fail, ovf;
	out_beat_t coef_q[$];

	function automatic logic [7:0] fmul(logic [7:0] a, logic [7:0] b);
		logic [8:0] x;
		logic [7:0] acc;
		x = {1'b0, a};
		acc = '0;
		for (int n = 0; n < 8; n++) begin
			if (b[n]) acc ^= x[7:0];
			x = {x[7:0], 1'b0};
			if (x[8]) x ^= reduce_poly;
			x[8] = 1'b0;
		end
		return acc;
	endfunction

	function automatic logic [7:0] fdiv(logic [7:0] a, logic [7:0] b);
		logic [7:0] r, base;
		int unsigned e;
		r = 8'd1;
		base = b;
		e = 254;
		while (e != 0) begin
			if (e[0]) r = fmul(r, base);
			base = fmul(base, base);
			e >>= 1;
		end
		return fmul(a, r);
	endfunction

	task automatic clear_sequence();
		for (int j = 0; j < MAX_LEN; j++) begin
			seq_mem[j] = '0;
			conn[j] = '0;
			prev_conn[j] = '0;
		end
		conn_len = 0;
		prev_len = 0;
		prev_pos = 0;
		prev_disc = '0;
		sym_cnt = 0;
		had_fail = 0;
		ovf = 0;
	endtask

	task automatic absorb_symbol(logic [7:0] sym);
		int unsigned i, shift, nlen, p;
		logic [7:0] d, k;
		logic [7:0] nxt [MAX_LEN];
		if (sym_cnt >= MAX_LEN) begin
			ovf = 1;
			return;
		end
		i = sym_cnt + 1;
		seq_mem[i-1] = sym;
		sym_cnt = i;
		d = sym;
		for (int j = 0; j < conn_len && j < MAX_LEN; j++)
			if (i >= j + 2) d ^= fmul(conn[j], seq_mem[(i - j - 2) % MAX_LEN]);
		if (d == 0) return;
		if (!had_fail) begin
			had_fail = 1;
			for (int j = 0; j < MAX_LEN; j++) conn[j] = '0;
			conn_len = i;
			prev_pos = i;
			prev_disc = d;
			prev_len = 0;
			return;
		end
		k = fdiv(d, prev_disc);
		shift = i - prev_pos - 1;
		nlen = shift + 1 + prev_len;
		if (nlen < conn_len) nlen = conn_len;
		if (nlen > MAX_LEN) nlen = MAX_LEN;
		for (int j = 0; j < MAX_LEN; j++) nxt[j] = '0;
		if (shift < MAX_LEN) nxt[shift] = k;
		for (int j = 0; j < prev_len; j++) begin
			p = shift + 1 + j;
			if (p < MAX_LEN) nxt[p] = fmul(prev_conn[j], k);
		end
		for (int j = 0; j < conn_len && j < MAX_LEN; j++) nxt[j] ^= conn[j];
		if (i - prev_pos + prev_len >= conn_len) begin
			for (int j = 0; j < MAX_LEN; j++) prev_conn[j] = conn[j];
			prev_len = conn_len;
			prev_pos = i;
			prev_disc = d;
		end
		for (int j = 0; j < MAX_LEN; j++) conn[j] = nxt[j];
		conn_len = nlen;
	endtask

	task automatic emit_coefficients();
		out_beat_t b;
		int unsigned len;
		len = (conn_len > MAX_LEN) ? MAX_LEN : conn_len;
		if (len == 0) begin
			b = '{coefficient: 8'd0, coefficient_index: '0, poly_length: '0,
				final_result: 1'b1, overflow: ovf};
			coef_q = {coef_q, b};
		end
		for (int j = 0; j < len; j++) begin
			b.coefficient = conn[j];
			b.coefficient_index = j[4:0];
			b.poly_length = len[5:0];
			b.final_result = (j + 1 == len);
			b.overflow = ovf;
			coef_q = {coef_q, b};
		end
		clear_sequence();
	endtask

	assign pending = coef_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_beat_t exp_b;
		if (!arst_n) begin
			reduce_poly = POLY_RESET;
			clear_sequence();
			coef_q.delete();
			fail_count <= 0;
			runs_done <= 0;
			coefs_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) reduce_poly = cfg_data;
			if (in_valid && in_ready) begin
				absorb_symbol(in_data.symbol);
				if (in_data.last) begin
					emit_coefficients();
					runs_done <= runs_done + 1;
				end
			end
			if (out_valid && out_ready) begin
				coefs_seen <= coefs_seen + 1;
				if (coef_q.size() == 0) begin
					$error("coefficient beat with nothing expected: %p", out_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_b = coef_q.pop_front();
					if (out_data.coefficient !== exp_b.coefficient)
						$error("coefficient: expected %0d, got %0d",
							exp_b.coefficient, out_data.coefficient);
					if (out_data.coefficient_index !== exp_b.coefficient_index)
						$error("coefficient_index: expected %0d, got %0d",
							exp_b.coefficient_index, out_data.coefficient_index);
					if (out_data.poly_length !== exp_b.poly_length)
						$error("poly_length: expected %0d, got %0d",
							exp_b.poly_length, out_data.poly_length);
					if (out_data.final_result !== exp_b.final_result)
						$error("final_result: expected %0d, got %0d",
							exp_b.final_result, out_data.final_result);
					if (out_data.overflow !== exp_b.overflow)
						$error("overflow: expected %0d, got %0d",
							exp_b.overflow, out_data.overflow);
					if (out_data !== exp_b) fail_count <= fail_count + 1;
				end
			end
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives symbol sequences and field polynomials into the Berlekamp-Massey
// block with random gaps and back-pressure; the checker gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import gfbm_pkg::*;

	localparam int MAX_LEN = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [POLY_W-1:0] cfg_data = '0;
	logic cfg_ready;
	int fail_count, pending, runs_done, coefs_seen;
	int sent;

	gfbm_if #(.T(in_beat_t)) in_ch ();
	gfbm_if #(.T(out_beat_t)) out_ch ();

	gf256_berlekamp_massey #(.MAX_LEN(MAX_LEN)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	gfbm_checker #(.MAX_LEN(MAX_LEN)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending),
		.runs_done(runs_done), .coefs_seen(coefs_seen)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// sink side: random stalls with calm stretches
	initial begin
		int g;
		bit calm;
		@(posedge arst_n);
		forever begin
			calm = ($urandom_range(0, 7) == 0);
			repeat ($urandom_range(5, 40)) begin
				@(posedge clk);
				g = calm ? 0 : gap_len();
				out_ch.ready <= (g == 0);
			end
		end
	end

	task automatic send_symbol(logic [7:0] sym, logic lst, bit may_idle);
		int g;
		g = may_idle ? gap_len() : 0;
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{symbol: sym, last: lst};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic drop_valid();
		in_ch.valid <= 1'b0;
	endtask

	// wait for all coefficients, let the clear sweep finish, then load the new polynomial
	task automatic drain_then_config(logic [POLY_W-1:0] p);
		drop_valid();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3 * MAX_LEN + 40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= p;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	logic [POLY_W-1:0] cur_poly = POLY_RESET;
	function automatic logic [7:0] gf_mul_tb(logic [7:0] a, logic [7:0] b);
		logic [7:0] acc;
		logic [8:0] x;
		acc = '0;
		x = {1'b0, a};
		for (int n = 0; n < 8; n++) begin
			if (b[n]) acc ^= x[7:0];
			x = {x[7:0], 1'b0};
			if (x[8]) x ^= cur_poly;
			x[8] = 1'b0;
		end
		return acc;
	endfunction

	// well-formed sequence: generated by a random short recurrence, with random noise symbols mixed in
	task automatic send_recurrence(int len, int order, bit idle);
		logic [7:0] s [$];
		logic [7:0] taps [8];
		logic [7:0] v;
		for (int j = 0; j < order; j++) taps[j] = 8'($urandom_range(0, 255));
		for (int i = 0; i < len; i++) begin
			if (i < order || order == 0)
				v = (order == 0) ? 8'd0 : 8'($urandom_range(0, 255));
			else begin
				v = 8'd0;
				for (int j = 0; j < order; j++) v ^= gf_mul_tb(taps[j], s[i-j-1]);
			end
			if ($urandom_range(0, 15) == 0) v = 8'($urandom_range(0, 255));
			s = {s, v};
			send_symbol(v, i == len - 1, idle);
		end
	endtask

	initial begin
		logic [POLY_W-1:0] polys [5];
		int ln;
		sent = 0;
		polys = '{9'h11B, 9'h100, 9'h1FF, 9'h12B, POLY_RESET};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single symbols, extremes, all-zero run, a long overflow run
		send_symbol(8'h00, 1'b1, 0);
		send_symbol(8'hFF, 1'b1, 0);
		send_symbol(8'h01, 1'b0, 0);
		send_symbol(8'h80, 1'b0, 0);
		send_symbol(8'h7F, 1'b1, 0);
		send_symbol(8'h00, 1'b0, 0);
		send_symbol(8'h00, 1'b1, 0);
		send_symbol(8'hAA, 1'b0, 0);
		send_symbol(8'h55, 1'b1, 0);
		for (int i = 0; i < MAX_LEN + 2; i++)
			send_symbol(8'($urandom_range(0, 255)), i == MAX_LEN + 1, 0);

		// random phases, one per field polynomial
		for (int ph = 0; ph < 5; ph++) begin
			drain_then_config(polys[ph]);
			cur_poly = polys[ph];
			repeat (2) begin
				case ($urandom_range(0, 9))
					0: ln = $urandom_range(MAX_LEN - 1, MAX_LEN + 3);
					1, 2: begin
						ln = $urandom_range(1, 8);
						for (int i = 0; i < ln; i++)
							send_symbol(8'($urandom_range(0, 255)), i == ln - 1, 1);
						ln = 0;
					end
					default: ln = $urandom_range(2, 10);
				endcase
				if (ln > 0) send_recurrence(ln, $urandom_range(0, 4), 1);
			end
		end
		drop_valid();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3 * MAX_LEN + 40) @(posedge clk);
		$display("run: %0d symbols over %0d sequences, %0d coefficient beats checked",
			sent, runs_done, coefs_seen);
		$display("run: six reduction-polynomial phases incl. overflow and stall cases");
		if (fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
